FILE: design/fpma_pkg.sv
// Shared types, constants and a helper function for the fit policy memory allocator.
package fpma_pkg;

  localparam int ADDR_W = 16;
  localparam int LEN_W = 16;
  localparam int ID_W = 16;
  localparam int CNT_W = 32;
  localparam int HC_W = 7;
  localparam int POL_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OWNER_SLOTS_DEF = 64;
  localparam int HOLE_SLOTS_DEF = 65;

  localparam logic [LEN_W-1:0] MEM_SIZE_RESET = 16'hFFFF;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE = 1'b1;

  localparam logic STATUS_OK = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  localparam logic REG_FIT_POLICY = 1'b0;
  localparam logic REG_MEMORY_SIZE = 1'b1;

  localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
  localparam logic [POL_W-1:0] POL_WORST = 2'd1;
  localparam logic [POL_W-1:0] POL_BEST = 2'd2;
  localparam logic [POL_W-1:0] POL_FIT_RESET = POL_FIRST;

  typedef enum logic [2:0] {
    CELL_HOLD = 3'd0,
    CELL_ROT  = 3'd1,
    CELL_DEL  = 3'd2,
    CELL_INS  = 3'd3,
    CELL_WR   = 3'd4
  } cell_op_t;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_OSCAN = 7'b0000010,
    ST_HSCAN = 7'b0000100,
    ST_EDIT  = 7'b0001000,
    ST_EDIT2 = 7'b0010000,
    ST_STAT  = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

FILE: design/fpma_if.sv
// Handshake channel interfaces for requests, results and configuration writes.
interface fpma_req_if;
  logic valid;
  logic ready;
  logic command;
  logic [fpma_pkg::ID_W-1:0] owner_id;
  logic [fpma_pkg::LEN_W-1:0] request_size;
  modport source (output valid, command, owner_id, request_size, input ready);
  modport sink (input valid, command, owner_id, request_size, output ready);
endinterface

interface fpma_rsp_if;
  logic valid;
  logic ready;
  logic status;
  logic [fpma_pkg::ADDR_W-1:0] start_address;
  logic [fpma_pkg::CNT_W-1:0] allocations_done;
  logic [fpma_pkg::CNT_W-1:0] units_allocated;
  logic [fpma_pkg::CNT_W-1:0] frees_done;
  logic [fpma_pkg::CNT_W-1:0] units_freed;
  logic [fpma_pkg::LEN_W-1:0] free_units_now;
  logic [fpma_pkg::LEN_W-1:0] smallest_hole;
  logic [fpma_pkg::LEN_W-1:0] largest_hole;
  logic [fpma_pkg::CNT_W-1:0] failures;
  logic [fpma_pkg::HC_W-1:0] hole_count;
  modport source (output valid, status, start_address, allocations_done, units_allocated,
                  frees_done, units_freed, free_units_now, smallest_hole, largest_hole,
                  failures, hole_count, input ready);
  modport sink (input valid, status, start_address, allocations_done, units_allocated,
                frees_done, units_freed, free_units_now, smallest_hole, largest_hole,
                failures, hole_count, output ready);
endinterface

interface fpma_cfg_if;
  logic valid;
  logic ready;
  logic addr;
  logic [fpma_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

FILE: design/fit_policy_memory_allocator.sv
// Top level: free-list allocator built on rotating hole and owner cell rows.
// The owner ring rotates once to find the owner, the hole ring once to pick or place
// the region, then once more to gather statistics; a free that merges with holes on both
// sides passes through one extra edit state. One request is in flight at a time, so a new
// request is not taken until the result of the last one has been issued.
// Reset restores one hole of 65535 units, an empty owner table and zero counters.
module fit_policy_memory_allocator #(
  parameter int OWNER_SLOTS = fpma_pkg::OWNER_SLOTS_DEF,
  parameter int HOLE_SLOTS = fpma_pkg::HOLE_SLOTS_DEF
) (
  input logic clk,
  input logic rst,
  fpma_cfg_if.sink cfg,
  fpma_req_if.sink req,
  fpma_rsp_if.source rsp
);
  import fpma_pkg::*;

  localparam int HUW = $clog2(HOLE_SLOTS + 1);
  localparam int OUW = $clog2(OWNER_SLOTS + 1);
  localparam int HIW = (HOLE_SLOTS > 1) ? $clog2(HOLE_SLOTS) : 1;
  localparam int OIW = (OWNER_SLOTS > 1) ? $clog2(OWNER_SLOTS) : 1;
  localparam int MAXN = (HOLE_SLOTS > OWNER_SLOTS) ? HOLE_SLOTS : OWNER_SLOTS;
  localparam int CW = $clog2(MAXN);
  localparam int HW = ADDR_W + LEN_W;
  localparam int OW = ID_W + ADDR_W + LEN_W;
  localparam int XW = HUW + OUW + CW;

  state_t state;
  logic [CW-1:0] cnt;
  logic cmd;
  logic [ID_W-1:0] who;
  logic [LEN_W-1:0] want;
  logic [POL_W-1:0] fit_policy;
  logic [HUW-1:0] holes_used;
  logic [OUW-1:0] owners_used;

  logic ofound;
  logic [OIW-1:0] k;
  logic [ADDR_W-1:0] rs;
  logic [LEN_W-1:0] rl;

  logic found;
  logic [HIW-1:0] pick;
  logic [ADDR_W-1:0] pstart;
  logic [LEN_W-1:0] plen;
  logic have_prev, have_next;
  logic [ADDR_W-1:0] prev_start, next_start;
  logic [LEN_W-1:0] prev_len, next_len;
  logic [HUW-1:0] p;

  logic [CNT_W-1:0] alloc_cnt, alloc_units, free_cnt, free_units, fail_cnt;
  logic [LEN_W-1:0] tot, smin, smax;
  logic res_status;
  logic [ADDR_W-1:0] res_where;

  cell_op_t hop, oop;
  logic [HIW-1:0] hidx;
  logic [OIW-1:0] oidx;
  logic [HW-1:0] hwdata, hhead;
  logic [OW-1:0] owdata, ohead;

  logic [ADDR_W-1:0] h_start, o_start;
  logic [LEN_W-1:0] h_len, o_len;
  logic [ID_W-1:0] o_ident;
  logic hvalid, ovalid, scan_end_o, scan_end_h;
  logic left, right, alloc_ok, free_ok, ok, cfg_fire, req_fire;

  fpma_chain #(.N(HOLE_SLOTS), .W(HW), .IW(HIW)) u_holes (
    .clk(clk), .op(hop), .idx(hidx), .wdata(hwdata), .head(hhead)
  );

  fpma_chain #(.N(OWNER_SLOTS), .W(OW), .IW(OIW)) u_owners (
    .clk(clk), .op(oop), .idx(oidx), .wdata(owdata), .head(ohead)
  );

  assign {h_start, h_len} = hhead;
  assign {o_ident, o_start, o_len} = ohead;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign cfg_fire = cfg.valid && cfg.ready;
  assign req_fire = req.valid && req.ready;

  assign hvalid = XW'(cnt) < XW'(holes_used);
  assign ovalid = XW'(cnt) < XW'(owners_used);
  assign scan_end_o = (cnt == CW'(OWNER_SLOTS - 1));
  assign scan_end_h = (cnt == CW'(HOLE_SLOTS - 1));

  assign left = (rl != '0) && have_prev &&
                (({1'b0, prev_start} + {1'b0, prev_len}) == {1'b0, rs});
  assign right = (rl != '0) && have_next &&
                 (({1'b0, rs} + {1'b0, rl}) == {1'b0, next_start});
  assign alloc_ok = found && (XW'(owners_used) < XW'(OWNER_SLOTS));
  assign free_ok = ofound &&
                   !((rl != '0) && !left && !right && (XW'(holes_used) >= XW'(HOLE_SLOTS)));
  assign ok = (cmd == CMD_ALLOC) ? alloc_ok : free_ok;

  always_comb begin
    hop = CELL_HOLD;
    hidx = '0;
    hwdata = '0;
    oop = CELL_HOLD;
    oidx = '0;
    owdata = '0;
    if (rst) begin
      hop = CELL_WR;
      hwdata = {ADDR_W'(0), MEM_SIZE_RESET};
    end else if (cfg_fire && cfg.addr == REG_MEMORY_SIZE) begin
      hop = CELL_WR;
      hwdata = {ADDR_W'(0), LEN_W'(cfg.data)};
    end else begin
      unique case (state)
        ST_OSCAN: oop = CELL_ROT;
        ST_HSCAN, ST_STAT: hop = CELL_ROT;
        ST_EDIT: begin
          if (ok && cmd == CMD_ALLOC) begin
            hidx = pick;
            if (want < plen) begin
              hop = CELL_WR;
              hwdata = {pstart + want, plen - want};
            end else begin
              hop = CELL_DEL;
            end
            oop = CELL_WR;
            oidx = OIW'(owners_used);
            owdata = {who, pstart, want};
          end else if (ok) begin
            oop = CELL_DEL;
            oidx = k;
            if (rl != '0) begin
              if (left) begin
                hop = CELL_WR;
                hidx = HIW'(p - 1'b1);
                hwdata = right ? {prev_start, prev_len + rl + next_len}
                               : {prev_start, prev_len + rl};
              end else if (right) begin
                hop = CELL_WR;
                hidx = HIW'(p);
                hwdata = {rs, next_len + rl};
              end else begin
                hop = CELL_INS;
                hidx = HIW'(p);
                hwdata = {rs, rl};
              end
            end
          end
        end
        ST_EDIT2: begin
          hop = CELL_DEL;
          hidx = HIW'(p);
        end
        default: begin
          hop = CELL_HOLD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      fit_policy <= POL_FIT_RESET;
      holes_used <= HUW'(1);
      owners_used <= '0;
      alloc_cnt <= '0;
      alloc_units <= '0;
      free_cnt <= '0;
      free_units <= '0;
      fail_cnt <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg.addr)
          REG_FIT_POLICY: fit_policy <= POL_W'(cfg.data);
          REG_MEMORY_SIZE: begin
            holes_used <= (cfg.data != '0) ? HUW'(1) : HUW'(0);
            owners_used <= '0;
          end
          default: fit_policy <= fit_policy;
        endcase
      end
      if (rsp.valid && rsp.ready && state != ST_DONE) rsp.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (req_fire) begin
            cmd <= req.command;
            who <= req.owner_id;
            want <= req.request_size;
            ofound <= 1'b0;
            found <= 1'b0;
            have_prev <= 1'b0;
            have_next <= 1'b0;
            p <= '0;
            rs <= '0;
            rl <= '0;
            cnt <= '0;
            state <= ST_OSCAN;
          end
        end
        ST_OSCAN: begin
          if (ovalid && !ofound && o_ident == who) begin
            ofound <= 1'b1;
            k <= OIW'(cnt);
            rs <= o_start;
            rl <= o_len;
          end
          if (scan_end_o) begin
            cnt <= '0;
            state <= ST_HSCAN;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_HSCAN: begin
          if (hvalid && h_len >= want) begin
            if (!found) begin
              found <= 1'b1;
              pick <= HIW'(cnt);
              pstart <= h_start;
              plen <= h_len;
            end else if ((fit_policy == POL_WORST && h_len > plen) ||
                         (fit_policy == POL_BEST && h_len < plen)) begin
              pick <= HIW'(cnt);
              pstart <= h_start;
              plen <= h_len;
            end
          end
          if (hvalid) begin
            if (h_start <= rs) begin
              have_prev <= 1'b1;
              prev_start <= h_start;
              prev_len <= h_len;
              p <= HUW'(cnt) + 1'b1;
            end else if (!have_next) begin
              have_next <= 1'b1;
              next_start <= h_start;
              next_len <= h_len;
            end
          end
          if (scan_end_h) begin
            cnt <= '0;
            state <= ST_EDIT;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_EDIT: begin
          tot <= '0;
          smin <= '0;
          smax <= '0;
          res_status <= ok ? STATUS_OK : STATUS_FAIL;
          res_where <= '0;
          state <= ST_STAT;
          if (!ok) begin
            fail_cnt <= sat_add(fail_cnt, CNT_W'(1));
          end else if (cmd == CMD_ALLOC) begin
            res_where <= pstart;
            alloc_cnt <= sat_add(alloc_cnt, CNT_W'(1));
            alloc_units <= sat_add(alloc_units, CNT_W'(want));
            owners_used <= owners_used + 1'b1;
            if (!(want < plen)) holes_used <= holes_used - 1'b1;
          end else begin
            res_where <= rs;
            free_cnt <= sat_add(free_cnt, CNT_W'(1));
            free_units <= sat_add(free_units, CNT_W'(rl));
            owners_used <= owners_used - 1'b1;
            if (rl != '0 && !left && !right) holes_used <= holes_used + 1'b1;
            if (left && right) state <= ST_EDIT2;
          end
        end
        ST_EDIT2: begin
          holes_used <= holes_used - 1'b1;
          state <= ST_STAT;
        end
        ST_STAT: begin
          if (hvalid) begin
            if (cnt == '0) begin
              tot <= h_len;
              smin <= h_len;
              smax <= h_len;
            end else begin
              tot <= tot + h_len;
              if (h_len < smin) smin <= h_len;
              if (h_len > smax) smax <= h_len;
            end
          end
          if (scan_end_h) begin
            cnt <= '0;
            state <= ST_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_DONE: begin
          if (!rsp.valid || rsp.ready) begin
            rsp.valid <= 1'b1;
            rsp.status <= res_status;
            rsp.start_address <= res_where;
            rsp.allocations_done <= alloc_cnt;
            rsp.units_allocated <= alloc_units;
            rsp.frees_done <= free_cnt;
            rsp.units_freed <= free_units;
            rsp.free_units_now <= tot;
            rsp.smallest_hole <= smin;
            rsp.largest_hole <= smax;
            rsp.failures <= fail_cnt;
            rsp.hole_count <= HC_W'(holes_used);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_holes_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(holes_used) <= XW'(HOLE_SLOTS))
    else $error("hole count exceeds the hole table");

  a_owners_bound: assert property (@(posedge clk) disable iff (rst)
    XW'(owners_used) <= XW'(OWNER_SLOTS))
    else $error("owner count exceeds the owner table");

  a_req_starts_scan: assert property (@(posedge clk) disable iff (rst)
    req_fire |=> (state == ST_OSCAN && cnt == '0))
    else $error("request transfer did not start the owner scan");

  a_fail_addr: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == STATUS_OK || rsp.start_address == '0))
    else $error("failed result carries a nonzero address");

  a_stats_order: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.hole_count != '0) |-> (rsp.smallest_hole <= rsp.largest_hole))
    else $error("smallest hole exceeds largest hole");
endmodule

FILE: design/fpma_cell.sv
// One storage cell of a shifting list: rotate, delete, insert or overwrite in place.
module fpma_cell #(
  parameter int W = 32,
  parameter int IW = 7,
  parameter int POS = 0
) (
  input  logic                 clk,
  input  fpma_pkg::cell_op_t   op,
  input  logic [IW-1:0]        idx,
  input  logic [W-1:0]         wdata,
  input  logic [W-1:0]         prev_q,
  input  logic [W-1:0]         next_q,
  output logic [W-1:0]         q
);
  import fpma_pkg::*;

  localparam logic [IW-1:0] MY_POS = IW'(POS);

  always_ff @(posedge clk) begin
    case (op)
      CELL_ROT: q <= next_q;
      CELL_DEL: begin
        if (MY_POS >= idx) q <= next_q;
      end
      CELL_INS: begin
        if (MY_POS > idx) q <= prev_q;
        else if (MY_POS == idx) q <= wdata;
      end
      CELL_WR: begin
        if (MY_POS == idx) q <= wdata;
      end
      default: q <= q;
    endcase
  end
endmodule

FILE: design/fpma_chain.sv
// Row of list cells linked to their neighbors, closed into a ring for rotation.
module fpma_chain #(
  parameter int N = 65,
  parameter int W = 32,
  parameter int IW = 7
) (
  input  logic                 clk,
  input  fpma_pkg::cell_op_t   op,
  input  logic [IW-1:0]        idx,
  input  logic [W-1:0]         wdata,
  output logic [W-1:0]         head
);
  import fpma_pkg::*;

  logic [W-1:0] q_arr [N];

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [W-1:0] prev_q;
    logic [W-1:0] next_q;
    if (i == 0) begin : g_first
      assign prev_q = wdata;
    end else begin : g_mid
      assign prev_q = q_arr[i-1];
    end
    if (i == N - 1) begin : g_last
      assign next_q = q_arr[0];
    end else begin : g_inner
      assign next_q = q_arr[i+1];
    end
    fpma_cell #(.W(W), .IW(IW), .POS(i)) u_cell (
      .clk(clk), .op(op), .idx(idx), .wdata(wdata),
      .prev_q(prev_q), .next_q(next_q), .q(q_arr[i])
    );
  end

  assign head = q_arr[0];
endmodule
